// ===== hdl/bal_pkg.sv =====
package bal_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 32;
    localparam int ANS_W    = 36;

    // Command codes
    localparam logic [4:0] FN_GET        = 5'd0;
    localparam logic [4:0] FN_SET        = 5'd1;
    localparam logic [4:0] FN_PUSH_BACK  = 5'd2;
    localparam logic [4:0] FN_PUSH_FRONT = 5'd3;
    localparam logic [4:0] FN_INSERT     = 5'd4;
    localparam logic [4:0] FN_POP_BACK   = 5'd5;
    localparam logic [4:0] FN_POP_FRONT  = 5'd6;
    localparam logic [4:0] FN_EXTRACT    = 5'd7;
    localparam logic [4:0] FN_REVERSE    = 5'd8;
    localparam logic [4:0] FN_ROTATE     = 5'd9;
    localparam logic [4:0] FN_SUM        = 5'd10;
    localparam logic [4:0] FN_MAX        = 5'd11;
    localparam logic [4:0] FN_SECOND_MAX = 5'd12;
    localparam logic [4:0] FN_MIN_INDEX  = 5'd13;
    localparam logic [4:0] FN_COUNT_ODD  = 5'd14;
    localparam logic [4:0] FN_SUM_EVEN   = 5'd15;
    localparam logic [4:0] FN_TRUNCATE   = 5'd16;
    localparam logic [4:0] FN_INIT       = 5'd17;
    localparam logic [4:0] FN_LENGTH     = 5'd18;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_WRITE,
        OP_INSERT,
        OP_REMOVE,
        OP_SUBROT,
        OP_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic [IDX_W-1:0]          lo;
        logic [IDX_W-1:0]          hi;
        logic signed [WORD_W-1:0]  word;
    } cell_ctl_t;

endpackage

// ===== hdl/bal_cell.sv =====
// One list entry. Every cell sees the same broadcast command and decides
// from its own index whether to hold, load, or take a neighbour's word.
module bal_cell import bal_pkg::*; (
    input  logic                      aclk,
    input  cell_ctl_t                 ctl,
    input  logic [IDX_W-1:0]          index,
    input  logic signed [WORD_W-1:0]  prev_data,
    input  logic signed [WORD_W-1:0]  next_data,
    input  logic signed [WORD_W-1:0]  rd_data,
    output logic signed [WORD_W-1:0]  data
);

    logic signed [WORD_W-1:0] data_reg, data_next;

    always_comb begin
        data_next = data_reg;
        case (ctl.op)
            OP_WRITE: begin
                if (index == ctl.lo) data_next = ctl.word;
            end
            OP_INSERT: begin
                if (index == ctl.lo) data_next = ctl.word;
                else if (index > ctl.lo) data_next = prev_data;
            end
            OP_REMOVE: begin
                if (index >= ctl.lo) data_next = next_data;
            end
            OP_SUBROT: begin
                if (index == ctl.lo) data_next = rd_data;
                else if (index > ctl.lo && index <= ctl.hi) data_next = prev_data;
            end
            OP_CLEAR: begin
                data_next = '0;
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== hdl/bounded_array_list_engine.sv =====
// Bounded array list engine: a list of up to sixteen signed 32-bit words held
// in a row of cells, one entry per cell.
// The command channel (s_*) carries one word of command fields; the result
// channel (m_*) returns one word per command with the answer, the list length
// after the command and a status code. Both channels use valid/ready.
// A command is taken only while the sequencer is idle. Get, set, push, pop,
// insert, extract, truncate, init and length finish in the single working
// state S_EXEC and then pass to S_DONE, from which the result is registered.
// Sum, odd count and even sum read one entry per cycle through the shared
// read port over the length (or prefix); max, second max and last min index
// walk the list the same way. Reverse steps once per entry of the range
// beyond its first, rotate once per unit of distance (at most 31), each step
// rotating a range by one.
// The result sits in an output register, so a new command is taken while the
// previous result waits; if the receiver stalls, the following command holds
// in its final state until the output register is free, and s_ready stays low.
// Reset (aresetn low, synchronous) empties the list and drops any result;
// no command is taken while it is held.
module bounded_array_list_engine import bal_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [4:0]                s_func,
    input  logic [3:0]                s_position,
    input  logic [3:0]                s_range_end,
    input  logic signed [31:0]        s_word,
    input  logic [4:0]                s_amount,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [35:0]        m_answer,
    output logic [4:0]                m_length,
    output logic [1:0]                m_status
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_WALK  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Latched command
    logic [4:0]                func_reg;
    logic [IDX_W-1:0]          pos_reg, rend_reg;
    logic signed [WORD_W-1:0]  word_reg;
    logic [4:0]                amt_reg;

    // Sequencer state
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic [4:0]                cnt_reg, cnt_next;
    logic [CNT_W-1:0]          limit_reg, limit_next;
    logic [IDX_W-1:0]          lo_reg, lo_next, hi_reg, hi_next, mi_reg, mi_next;
    logic                      rot_reg, rot_next;
    logic signed [ANS_W-1:0]   acc_reg, acc_next, ans_reg, ans_next;
    logic signed [WORD_W-1:0]  m1_reg, m1_next, m2_reg, m2_next, mv_reg, mv_next;
    logic                      have2_reg, have2_next;
    logic [1:0]                st_reg, st_next;

    // Output register
    logic                      mv_out_reg;
    logic signed [ANS_W-1:0]   ans_out_reg;
    logic [CNT_W-1:0]          len_out_reg;
    logic [1:0]                st_out_reg;

    // Cell row
    cell_ctl_t                 ctl;
    logic [IDX_W-1:0]          rd_addr;
    logic signed [WORD_W-1:0]  rd_data;
    logic signed [WORD_W-1:0]  cell_q    [CAPACITY];
    logic signed [WORD_W-1:0]  prev_arr  [CAPACITY];
    logic signed [WORD_W-1:0]  next_arr  [CAPACITY];

    logic [IDX_W-1:0]          p_idx;
    logic signed [ANS_W-1:0]   x_ext;
    logic                      out_free;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign prev_arr[g] = '0;
        end else begin : g_mid
            assign prev_arr[g] = cell_q[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign next_arr[g] = '0;
        end else begin : g_inner
            assign next_arr[g] = cell_q[g+1];
        end
        bal_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .index     (IDX_W'(g)),
            .prev_data (prev_arr[g]),
            .next_data (next_arr[g]),
            .rd_data   (rd_data),
            .data      (cell_q[g])
        );
    end

    // Single shared read port into the row.
    assign rd_data  = cell_q[rd_addr];
    assign x_ext    = ANS_W'(rd_data);
    assign out_free = !mv_out_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && aresetn;

    // Target index for pushes and pops; the command position otherwise.
    always_comb begin
        if (func_reg == FN_PUSH_BACK) p_idx = fill_reg[IDX_W-1:0];
        else if (func_reg == FN_POP_BACK) p_idx = IDX_W'(fill_reg - 1'b1);
        else if (func_reg inside {FN_PUSH_FRONT, FN_POP_FRONT}) p_idx = '0;
        else p_idx = pos_reg;
    end

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        cnt_next   = cnt_reg;
        limit_next = limit_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mi_next    = mi_reg;
        rot_next   = rot_reg;
        acc_next   = acc_reg;
        ans_next   = ans_reg;
        m1_next    = m1_reg;
        m2_next    = m2_reg;
        mv_next    = mv_reg;
        have2_next = have2_reg;
        st_next    = st_reg;
        ctl.op     = OP_HOLD;
        ctl.lo     = lo_reg;
        ctl.hi     = hi_reg;
        ctl.word   = word_reg;
        rd_addr    = p_idx;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_EXEC;
            end
            S_EXEC: begin
                ans_next   = '0;
                st_next    = ST_OK;
                acc_next   = '0;
                cnt_next   = '0;
                state_next = S_DONE;
                if (func_reg == FN_GET) begin
                    if ({1'b0, pos_reg} < fill_reg) ans_next = x_ext;
                    else begin
                        ans_next = '1;
                        st_next  = ST_RANGE;
                    end
                end else if (func_reg == FN_SET) begin
                    ctl.lo = pos_reg;
                    if ({1'b0, pos_reg} < fill_reg) ctl.op = OP_WRITE;
                    else st_next = ST_RANGE;
                end else if (func_reg inside {FN_PUSH_BACK, FN_PUSH_FRONT, FN_INSERT}) begin
                    ctl.lo = p_idx;
                    if (fill_reg >= CNT_W'(CAPACITY)) st_next = ST_FULL;
                    else if (func_reg == FN_INSERT && {1'b0, pos_reg} > fill_reg)
                        st_next = ST_RANGE;
                    else begin
                        ctl.op    = OP_INSERT;
                        fill_next = fill_reg + 1'b1;
                    end
                end else if (func_reg inside {FN_POP_BACK, FN_POP_FRONT, FN_EXTRACT}) begin
                    ctl.lo = p_idx;
                    if (fill_reg == '0) st_next = ST_EMPTY;
                    else if (func_reg == FN_EXTRACT && {1'b0, pos_reg} >= fill_reg)
                        st_next = ST_RANGE;
                    else begin
                        ans_next  = x_ext;
                        ctl.op    = OP_REMOVE;
                        fill_next = fill_reg - 1'b1;
                    end
                end else if (func_reg == FN_REVERSE) begin
                    if ({1'b0, pos_reg} >= fill_reg || {1'b0, rend_reg} >= fill_reg)
                        st_next = ST_RANGE;
                    else if (pos_reg < rend_reg) begin
                        lo_next    = pos_reg;
                        hi_next    = rend_reg;
                        rot_next   = 1'b0;
                        state_next = S_SHIFT;
                    end
                end else if (func_reg == FN_ROTATE) begin
                    if (fill_reg != '0 && amt_reg != '0) begin
                        lo_next    = '0;
                        hi_next    = IDX_W'(fill_reg - 1'b1);
                        cnt_next   = amt_reg;
                        rot_next   = 1'b1;
                        state_next = S_SHIFT;
                    end
                end else if (func_reg == FN_SUM) begin
                    limit_next = fill_reg;
                    state_next = S_WALK;
                end else if (func_reg inside {FN_MAX, FN_SECOND_MAX, FN_MIN_INDEX}) begin
                    rd_addr = '0;
                    if (fill_reg == '0) st_next = ST_EMPTY;
                    else begin
                        m1_next    = rd_data;
                        m2_next    = rd_data;
                        mv_next    = rd_data;
                        have2_next = 1'b0;
                        mi_next    = '0;
                        cnt_next   = 5'd1;
                        limit_next = fill_reg;
                        state_next = S_WALK;
                    end
                end else if (func_reg inside {FN_COUNT_ODD, FN_SUM_EVEN}) begin
                    if (amt_reg > 5'(fill_reg)) st_next = ST_RANGE;
                    else begin
                        limit_next = CNT_W'(amt_reg);
                        state_next = S_WALK;
                    end
                end else if (func_reg == FN_TRUNCATE) begin
                    if (amt_reg > 5'(fill_reg)) st_next = ST_RANGE;
                    else fill_next = fill_reg - CNT_W'(amt_reg);
                end else if (func_reg == FN_INIT) begin
                    if (amt_reg > 5'(CAPACITY)) st_next = ST_RANGE;
                    else begin
                        ctl.op    = OP_CLEAR;
                        fill_next = CNT_W'(amt_reg);
                    end
                end else if (func_reg == FN_LENGTH) begin
                    ans_next = ANS_W'(fill_reg);
                end
            end
            S_WALK: begin
                rd_addr = cnt_reg[IDX_W-1:0];
                if (cnt_reg == 5'(limit_reg)) begin
                    state_next = S_DONE;
                    if (func_reg == FN_MAX) ans_next = ANS_W'(m1_reg);
                    else if (func_reg == FN_SECOND_MAX)
                        ans_next = have2_reg ? ANS_W'(m2_reg) : ANS_W'(m1_reg);
                    else if (func_reg == FN_MIN_INDEX) ans_next = ANS_W'(mi_reg);
                    else ans_next = acc_reg;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                    if (func_reg == FN_SUM) acc_next = acc_reg + x_ext;
                    else if (func_reg == FN_COUNT_ODD) begin
                        if (rd_data[0]) acc_next = acc_reg + ANS_W'(1);
                    end else if (func_reg == FN_SUM_EVEN) begin
                        if (!rd_data[0]) acc_next = acc_reg + x_ext;
                    end else begin
                        if (rd_data > m1_reg) begin
                            m2_next    = m1_reg;
                            m1_next    = rd_data;
                            have2_next = 1'b1;
                        end else if (!have2_reg || rd_data > m2_reg) begin
                            m2_next    = rd_data;
                            have2_next = 1'b1;
                        end
                        if (rd_data <= mv_reg) begin
                            mv_next = rd_data;
                            mi_next = cnt_reg[IDX_W-1:0];
                        end
                    end
                end
            end
            S_SHIFT: begin
                // One-step right rotate of the range lo..hi.
                rd_addr = hi_reg;
                ctl.op  = OP_SUBROT;
                if (rot_reg) begin
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == 5'd1) state_next = S_DONE;
                end else begin
                    lo_next = lo_reg + 1'b1;
                    if (lo_reg + 1'b1 == hi_reg) state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            mv_out_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (state_reg == S_DONE && out_free) mv_out_reg <= 1'b1;
            else if (m_ready) mv_out_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            func_reg <= s_func;
            pos_reg  <= s_position;
            rend_reg <= s_range_end;
            word_reg <= s_word;
            amt_reg  <= s_amount;
        end
        cnt_reg   <= cnt_next;
        limit_reg <= limit_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mi_reg    <= mi_next;
        rot_reg   <= rot_next;
        acc_reg   <= acc_next;
        ans_reg   <= ans_next;
        m1_reg    <= m1_next;
        m2_reg    <= m2_next;
        mv_reg    <= mv_next;
        have2_reg <= have2_next;
        st_reg    <= st_next;
        if (state_reg == S_DONE && out_free) begin
            ans_out_reg <= ans_reg;
            len_out_reg <= fill_reg;
            st_out_reg  <= st_reg;
        end
    end

    assign m_valid  = mv_out_reg;
    assign m_answer = ans_out_reg;
    assign m_length = len_out_reg;
    assign m_status = st_out_reg;

    // The list never grows past its capacity.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    // An accepted command is worked on in the following cycle.
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_EXEC)
        else $error("accepted command not executed");

    // A range reversal always works on a non-empty span.
    a_reverse_span: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SHIFT && !rot_reg |-> lo_reg < hi_reg)
        else $error("reverse span collapsed");

    // A fresh result only appears after the final state.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_DONE))
        else $error("result without completed command");

endmodule
